/* hw/rtl/heater_safety_interlock_core_defines.svh */
// Assertion macros for the heater safety interlock RTL.
// Included by the top level; the checks are removed when SYNTHESIS is defined.
`ifndef HEATER_SAFETY_INTERLOCK_CORE_DEFINES_SVH
`define HEATER_SAFETY_INTERLOCK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define HSI_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("interlock assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("interlock assertion failed");

`else

`define HSI_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define HSI_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* hw/rtl/hsi_pkg.sv */
// Shared types, codes and helpers of the heater safety interlock.
// Used by hsi_state and heater_safety_interlock_core; depends on nothing.
package hsi_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [63:0] TIME_SAT =
		(TIME_BITS == 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUNTIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 2'd2;

	localparam logic [CFG_W-1:0] MAX_RUNTIME_RST = 32'd3600000;
	localparam logic [CFG_W-1:0] SAFETY_DELAY_RST = 32'd60000;
	localparam logic [CFG_W-1:0] REPORT_PERIOD_RST = 32'd60000;

	// Link mode codes as seen on the result.
	localparam logic [1:0] LINK_NORMAL = 2'd0;
	localparam logic [1:0] LINK_PENDING = 2'd1;
	localparam logic [1:0] LINK_SAFETY = 2'd2;

	// Off cause codes.
	localparam logic [1:0] OFF_NONE = 2'd0;
	localparam logic [1:0] OFF_COMMAND = 2'd1;
	localparam logic [1:0] OFF_RUNTIME = 2'd2;
	localparam logic [1:0] OFF_SAFETY = 2'd3;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'b001,
		MODE_PENDING = 3'b010,
		MODE_SAFETY  = 3'b100
	} hsi_mode_t;

	typedef struct packed {
		logic relay_sense;
		logic command_on;
		logic command_valid;
		logic link_up;
	} hsi_tick_t;

	typedef struct packed {
		logic [CFG_W-1:0] report_period_ms;
		logic [CFG_W-1:0] safety_delay_ms;
		logic [CFG_W-1:0] max_runtime_ms;
	} hsi_cfg_t;

	typedef struct packed {
		logic       sense_level;
		logic       sense_changed;
		logic [1:0] off_cause;
		logic [1:0] link_mode;
		logic       report_state;
		logic       relay_drive;
	} hsi_result_t;

	// A register value above the counter range saturates to the largest count.
	function automatic logic [TIME_BITS-1:0] to_counter(input logic [CFG_W-1:0] v);
		logic [63:0] wide;
		wide = 64'(v);
		if (wide > TIME_SAT)
			return TIME_BITS'(TIME_SAT);
		return TIME_BITS'(wide);
	endfunction

	function automatic logic [1:0] mode_code(input hsi_mode_t m);
		logic [1:0] code;
		unique case (m)
			MODE_NORMAL:  code = LINK_NORMAL;
			MODE_PENDING: code = LINK_PENDING;
			MODE_SAFETY:  code = LINK_SAFETY;
			default:      code = LINK_NORMAL;
		endcase
		return code;
	endfunction

endpackage

/* hw/rtl/hsi_state.sv */
// Interlock state and per-tick update: command, link mode, report timer,
// runtime limit, safety override and feedback edge. Depends on hsi_pkg.
module hsi_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  hsi_pkg::hsi_tick_t  tick,
	input  hsi_pkg::hsi_cfg_t   cfg,
	output hsi_pkg::hsi_result_t result
);

	hsi_pkg::hsi_mode_t mode_q, mode_n;
	logic heater_q, heater_n;
	logic armed_q, armed_n;
	logic last_sense_q;
	logic [hsi_pkg::TIME_BITS-1:0] runtime_q, runtime_n;
	logic [hsi_pkg::TIME_BITS-1:0] pending_q, pending_n;
	logic [hsi_pkg::TIME_BITS-1:0] report_q, report_n;

	logic fresh;
	logic report;
	logic [1:0] cause;

	always_comb begin
		heater_n = heater_q;
		armed_n = armed_q;
		runtime_n = runtime_q;
		pending_n = pending_q;
		report_n = report_q;
		mode_n = mode_q;
		fresh = 1'b0;
		report = 1'b0;
		cause = hsi_pkg::OFF_NONE;

		if (tick.command_valid) begin
			heater_n = tick.command_on;
			report = 1'b1;
			if (tick.command_on) begin
				armed_n = 1'b1;
				runtime_n = hsi_pkg::to_counter(cfg.max_runtime_ms);
				fresh = 1'b1;
			end else begin
				armed_n = 1'b0;
				runtime_n = '0;
				cause = hsi_pkg::OFF_COMMAND;
			end
		end

		unique case (mode_q)
			hsi_pkg::MODE_NORMAL: begin
				if (!tick.link_up) begin
					mode_n = hsi_pkg::MODE_PENDING;
					pending_n = hsi_pkg::to_counter(cfg.safety_delay_ms);
				end
			end
			hsi_pkg::MODE_PENDING: begin
				if (tick.link_up) begin
					mode_n = hsi_pkg::MODE_NORMAL;
				end else if (pending_q == '0) begin
					mode_n = hsi_pkg::MODE_SAFETY;
				end else begin
					pending_n = pending_q - hsi_pkg::TIME_BITS'(1);
				end
			end
			hsi_pkg::MODE_SAFETY: begin
				if (tick.link_up)
					mode_n = hsi_pkg::MODE_NORMAL;
			end
			default: mode_n = hsi_pkg::MODE_NORMAL;
		endcase

		if (report_q == '0) begin
			report = 1'b1;
			report_n = hsi_pkg::to_counter(cfg.report_period_ms);
		end else begin
			report_n = report_q - hsi_pkg::TIME_BITS'(1);
		end

		// The tick that loads the runtime counter does not test it.
		if (armed_n && heater_n && !fresh) begin
			if (runtime_n == '0) begin
				heater_n = 1'b0;
				armed_n = 1'b0;
				report = 1'b1;
				cause = hsi_pkg::OFF_RUNTIME;
			end else begin
				runtime_n = runtime_n - hsi_pkg::TIME_BITS'(1);
			end
		end

		if (mode_n == hsi_pkg::MODE_SAFETY && heater_n) begin
			heater_n = 1'b0;
			armed_n = 1'b0;
			runtime_n = '0;
			report = 1'b1;
			cause = hsi_pkg::OFF_SAFETY;
		end
	end

	always_comb begin
		result.relay_drive = heater_n;
		result.report_state = report;
		result.link_mode = hsi_pkg::mode_code(mode_n);
		result.off_cause = cause;
		result.sense_changed = tick.relay_sense ^ last_sense_q;
		result.sense_level = tick.relay_sense;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hsi_pkg::MODE_NORMAL;
			heater_q <= 1'b0;
			armed_q <= 1'b0;
			last_sense_q <= 1'b0;
			runtime_q <= '0;
			pending_q <= '0;
			report_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			heater_q <= heater_n;
			armed_q <= armed_n;
			last_sense_q <= tick.relay_sense;
			runtime_q <= runtime_n;
			pending_q <= pending_n;
			report_q <= report_n;
		end
	end

endmodule

/* hw/rtl/heater_safety_interlock_core.sv */
// Heater safety interlock: one millisecond tick item in, one status item out.
//
// s_axis carries one tick per item: link status, an optional on/off command
// and the sampled relay feedback. m_axis carries the relay drive, the report
// request, the link mode, the cause of an off event and the feedback edge.
// The cfg port writes max runtime, safety delay and report period; write it
// only while no item is in flight.
//
// Throughput: one item per cycle while m_axis does not stall; the
// whole update is one pass of logic between the accepted tick and
// the output register. When m_axis stalls, one more item is taken into a
// skid register, after which s_axis_tready drops until the output drains.
// Reset clears the interlock state (normal mode, relay off, report due on
// the first tick), restores the register defaults and empties the output.
`include "heater_safety_interlock_core_defines.svh"

module heater_safety_interlock_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hsi_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// link_up, command_valid, command_on, relay_sense, then zero padding
	input  logic [7:0]                         s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// relay_drive, report_state, link_mode[1:0], off_cause[1:0],
	// sense_changed, sense_level
	output logic [7:0]                         m_axis_tdata
);

	hsi_pkg::hsi_cfg_t cfg_q;
	hsi_pkg::hsi_tick_t tick;
	hsi_pkg::hsi_result_t result;
	hsi_pkg::hsi_result_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic accept, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_runtime_ms <= hsi_pkg::MAX_RUNTIME_RST;
			cfg_q.safety_delay_ms <= hsi_pkg::SAFETY_DELAY_RST;
			cfg_q.report_period_ms <= hsi_pkg::REPORT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsi_pkg::REG_MAX_RUNTIME:   cfg_q.max_runtime_ms <= cfg_data;
				hsi_pkg::REG_SAFETY_DELAY:  cfg_q.safety_delay_ms <= cfg_data;
				hsi_pkg::REG_REPORT_PERIOD: cfg_q.report_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tick.link_up = s_axis_tdata[0];
	assign tick.command_valid = s_axis_tdata[1];
	assign tick.command_on = s_axis_tdata[2];
	assign tick.relay_sense = s_axis_tdata[3];

	assign s_axis_tready = !skid_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign pop = out_valid_q && m_axis_tready;

	hsi_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.tick   (tick),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	// The skid register only fills behind a held output item.
	`HSI_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	// Any off event leaves the relay off in the same result.
	`HSI_ASSERT_IMPL(a_off_cause_relay, clk, arst_n,
		out_valid_q && (out_q.off_cause != hsi_pkg::OFF_NONE), !out_q.relay_drive)
	// Safety mode never drives the relay.
	`HSI_ASSERT_IMPL(a_safety_relay, clk, arst_n,
		out_valid_q && (out_q.link_mode == hsi_pkg::LINK_SAFETY), !out_q.relay_drive)
	// An item taken while the output stalls lands in the skid register.
	`HSI_ASSERT_NEXT(a_stall_to_skid, clk, arst_n,
		accept && out_valid_q && !m_axis_tready, skid_valid_q)

endmodule
